// ===== hw/rtl/kcl_pkg.sv =====
// Shared types and constants for the keypad code lock.
// No dependencies; imported by kcl_core, kcl_skid and keypad_code_lock_unit.
`default_nettype none

package kcl_pkg;

  localparam int CODE_LEN = 4;
  localparam int IDX_W    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam int CNT_W    = $clog2(CODE_LEN + 1);

  localparam int KEY_W   = 8;
  localparam int PHASE_W = 3;
  localparam int DIGIT_W = 3;
  localparam int TRIES_W = 3;
  localparam int SEC_W   = 6;
  localparam int EVENT_W = 4;
  localparam int CFG_W   = 6;

  localparam logic [TRIES_W-1:0] MAX_ATT_RST  = 3'd5;
  localparam logic [SEC_W-1:0]   LOCK_SEC_RST = 6'd20;
  localparam logic [KEY_W-1:0]   KEY_YES      = 8'h31;  // '1'

  typedef enum logic {
    CFG_MAX_ATTEMPTS = 1'b0,
    CFG_LOCKOUT_SEC  = 1'b1
  } cfg_idx_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_SET    = 3'd0,
    PH_ENTRY  = 3'd1,
    PH_LOCK   = 3'd2,
    PH_PROMPT = 3'd3,
    PH_OPEN   = 3'd4
  } phase_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE     = 4'd0,
    EV_KEY      = 4'd1,
    EV_STORED   = 4'd2,
    EV_WRONG    = 4'd3,
    EV_OPENED   = 4'd4,
    EV_LOCKOUT  = 4'd5,
    EV_PROMPT   = 4'd6,
    EV_RESET_Y  = 4'd7,
    EV_RESET_N  = 4'd8
  } event_e;

  typedef struct packed {
    phase_e             phase;
    logic [DIGIT_W-1:0] digits;
    logic [TRIES_W-1:0] tries;
    logic [SEC_W-1:0]   seconds;
    event_e             ev;
    logic               lamp_waiting;
    logic               lamp_lockout;
    logic               lamp_open;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kcl_core.sv =====
// Lock state machine: phase, code stores, digit count, attempts, countdown.
// Depends on kcl_pkg. Produces one result_t per accepted beat.
`default_nettype none

module kcl_core
  import kcl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic               mode_i,
  input  wire logic [KEY_W-1:0]   key_i,
  input  wire logic [TRIES_W-1:0] max_attempts_i,
  input  wire logic [SEC_W-1:0]   lockout_sec_i,
  output result_t                 result_o
);

  phase_e                         phase_q, phase_d;
  logic                           present_q, present_d;
  logic [CNT_W-1:0]               digit_q, digit_d;
  logic [TRIES_W-1:0]             tries_q, tries_d;
  logic [SEC_W-1:0]               count_q, count_d;
  logic [CODE_LEN-1:0][KEY_W-1:0] stored_q, stored_d;
  logic [CODE_LEN-1:0][KEY_W-1:0] entered_q, entered_d;

  logic [IDX_W-1:0] idx;
  logic             last_key;
  logic             match;
  event_e           ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SET;
      present_q <= 1'b0;
      digit_q   <= '0;
      tries_q   <= MAX_ATT_RST;
      count_q   <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      present_q <= present_d;
      digit_q   <= digit_d;
      tries_q   <= tries_d;
      count_q   <= count_d;
    end
  end

  // code stores are only compared once fully written
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stored_q  <= stored_d;
      entered_q <= entered_d;
    end
  end

  always_comb begin
    idx      = (digit_q >= CNT_W'(CODE_LEN)) ? '0 : IDX_W'(digit_q);
    last_key = (idx == IDX_W'(CODE_LEN - 1));

    phase_d   = phase_q;
    present_d = present_q;
    digit_d   = digit_q;
    tries_d   = tries_q;
    count_d   = count_q;
    stored_d  = stored_q;
    entered_d = entered_q;
    ev        = EV_NONE;

    entered_d[idx] = key_i;
    if (phase_q != PH_ENTRY || mode_i) begin
      entered_d = entered_q;
    end
    match = present_q && (stored_q == entered_d);

    if (mode_i) begin
      if (phase_q == PH_LOCK) begin
        if (count_q <= SEC_W'(1)) begin
          count_d = '0;
          phase_d = PH_PROMPT;
          ev      = EV_PROMPT;
        end else begin
          count_d = count_q - SEC_W'(1);
        end
      end
    end else begin
      case (phase_q)
        PH_SET: begin
          stored_d[idx] = key_i;
          if (!last_key) begin
            digit_d = CNT_W'(idx) + CNT_W'(1);
            ev      = EV_KEY;
          end else begin
            digit_d   = '0;
            present_d = 1'b1;
            tries_d   = max_attempts_i;
            phase_d   = PH_ENTRY;
            ev        = EV_STORED;
          end
        end
        PH_ENTRY: begin
          if (!last_key) begin
            digit_d = CNT_W'(idx) + CNT_W'(1);
            ev      = EV_KEY;
          end else begin
            digit_d = '0;
            if (match) begin
              phase_d = PH_OPEN;
              ev      = EV_OPENED;
            end else if (tries_q <= TRIES_W'(1)) begin
              tries_d = '0;
              count_d = lockout_sec_i;
              phase_d = PH_LOCK;
              ev      = EV_LOCKOUT;
            end else begin
              tries_d = tries_q - TRIES_W'(1);
              ev      = EV_WRONG;
            end
          end
        end
        PH_PROMPT: begin
          digit_d = '0;
          if (key_i == KEY_YES) begin
            present_d = 1'b0;
            tries_d   = max_attempts_i;
            phase_d   = PH_SET;
            ev        = EV_RESET_Y;
          end else begin
            tries_d = TRIES_W'(1);
            phase_d = PH_ENTRY;
            ev      = EV_RESET_N;
          end
        end
        default: begin
          ev = EV_NONE;
        end
      endcase
    end

    result_o.phase        = phase_d;
    result_o.digits       = DIGIT_W'(digit_d);
    result_o.tries        = tries_d;
    result_o.seconds      = count_d;
    result_o.ev           = ev;
    result_o.lamp_waiting = (phase_d == PH_ENTRY);
    result_o.lamp_lockout = (phase_d == PH_LOCK);
    result_o.lamp_open    = (phase_d == PH_OPEN);
  end

  // open is final
  a_open_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_OPEN |=> phase_q == PH_OPEN)
    else $error("lock left open phase");

  a_lock_no_tries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LOCK |-> tries_q == '0)
    else $error("lockout with attempts remaining");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q < CNT_W'(CODE_LEN))
    else $error("digit count out of range");

  a_set_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SET |-> !present_q)
    else $error("code present while setting code");

endmodule

`default_nettype wire

// ===== hw/rtl/kcl_skid.sv =====
// Two-slot output buffer: output register plus skid slot for result beats.
// Depends on kcl_pkg for result_t. Upstream stall is registered.
`default_nettype none

module kcl_skid
  import kcl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  result_t   data_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic stall_i,
  output result_t   data_o
);

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_free;

  assign out_free = !out_valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot filled ahead of output register");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("beat pushed into full buffer");

endmodule

`default_nettype wire

// ===== hw/rtl/keypad_code_lock_unit.sv =====
// Top level of the keypad code lock: config registers, lock core, output buffer.
// Depends on kcl_pkg, kcl_core and kcl_skid.
`default_nettype none

// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per key press
//   (mode_i = 0, key_i = character) or one-second tick (mode_i = 1).
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   beat per input beat: phase, digit count, tries left, seconds left,
//   event code and the three lamps, all as they stand after that beat.
//   Results are registered: an accepted beat goes to the result register, or to
//   the skid slot while the receiver stalls. Throughput is one beat per cycle
//   while in_stall_o is low; the state update and the four-byte code compare
//   are one pass of logic. A two-slot output buffer (result register plus skid
//   slot) decouples the sides: while the receiver stalls, one more beat is still
//   taken, then in_stall_o rises (from a register) until the receiver takes a beat.
//   Config (cfg_we_i, cfg_idx_i, cfg_wdata_i): index 0 max_attempts (low 3
//   bits), index 1 lockout_seconds (low 6 bits); write only while idle.
//   Reset: setting-code phase, no code stored, attempts 5, lockout 20 s,
//   buffer empty.
module keypad_code_lock_unit
  import kcl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               mode_i,
  input  wire logic [KEY_W-1:0]   key_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [PHASE_W-1:0]      phase_o,
  output logic [DIGIT_W-1:0]      digits_entered_o,
  output logic [TRIES_W-1:0]      tries_left_o,
  output logic [SEC_W-1:0]        seconds_left_o,
  output logic [EVENT_W-1:0]      event_res_o,
  output logic                    lamp_waiting_o,
  output logic                    lamp_lockout_o,
  output logic                    lamp_open_o
);

  logic [TRIES_W-1:0] max_att_q;
  logic [SEC_W-1:0]   lock_sec_q;
  logic               accept;
  logic               buf_full;
  result_t            core_res;
  result_t            out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_att_q  <= MAX_ATT_RST;
      lock_sec_q <= LOCK_SEC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_ATTEMPTS: max_att_q  <= cfg_wdata_i[TRIES_W-1:0];
        CFG_LOCKOUT_SEC:  lock_sec_q <= cfg_wdata_i[SEC_W-1:0];
        default: begin
          max_att_q <= max_att_q;
        end
      endcase
    end
  end

  // stall only when the skid slot is occupied
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  kcl_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .mode_i         (mode_i),
    .key_i          (key_i),
    .max_attempts_i (max_att_q),
    .lockout_sec_i  (lock_sec_q),
    .result_o       (core_res)
  );

  kcl_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (core_res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_res)
  );

  assign phase_o          = out_res.phase;
  assign digits_entered_o = out_res.digits;
  assign tries_left_o     = out_res.tries;
  assign seconds_left_o   = out_res.seconds;
  assign event_res_o      = out_res.ev;
  assign lamp_waiting_o   = out_res.lamp_waiting;
  assign lamp_lockout_o   = out_res.lamp_lockout;
  assign lamp_open_o      = out_res.lamp_open;

  a_lamps_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({lamp_waiting_o, lamp_lockout_o, lamp_open_o}))
    else $error("more than one lamp lit");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat produced no result");

endmodule

`default_nettype wire

// ===== tb/keypad_code_lock_unit_tb.sv =====
// Testbench for keypad_code_lock_unit: key presses and one-second ticks with
// random gaps and stalls, every status beat predicted and checked by field.
// Depends on kcl_pkg and the keypad_code_lock_unit RTL.
`timescale 1ns / 100ps

module keypad_code_lock_unit_tb
  import kcl_pkg::*;
();

  localparam logic MODE_KEY    = 1'b0;
  localparam logic MODE_TICK   = 1'b1;
  localparam int   STALL_LIMIT = 2000;  // cycles with no beat on either side
  localparam int   LONG_HOLD   = 200;   // receiver hold-off that fills the buffer
  localparam int   PRINT_CAP   = 200;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_e cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall_o;
  logic mode;
  logic [KEY_W-1:0] key;
  logic out_valid_o;
  logic out_stall;
  logic [PHASE_W-1:0] phase_o;
  logic [DIGIT_W-1:0] digits_entered_o;
  logic [TRIES_W-1:0] tries_left_o;
  logic [SEC_W-1:0] seconds_left_o;
  logic [EVENT_W-1:0] event_res_o;
  logic lamp_waiting_o;
  logic lamp_lockout_o;
  logic lamp_open_o;

  // Lock model: own copy of the config and the lock state
  logic [TRIES_W-1:0] cfg_attempts;
  logic [SEC_W-1:0]   cfg_secs;
  phase_e             lk_phase;
  logic               lk_have_code;
  logic [KEY_W-1:0]   lk_secret [CODE_LEN];
  logic [KEY_W-1:0]   lk_typed [CODE_LEN];
  logic [DIGIT_W-1:0] lk_digits;
  logic [TRIES_W-1:0] lk_tries;
  logic [SEC_W-1:0]   lk_secs;

  result_t pending_status [$];      // status beats still owed by the block
  logic [KEY_W-1:0] entry_plan [CODE_LEN];
  int  mismatches = 0;
  bit  src_idle_en;
  bit  sink_idle_en;
  int  sink_hold_len = 0;           // set by a test, consumed by the receiver

  keypad_code_lock_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode),
    .key_i           (key),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .phase_o         (phase_o),
    .digits_entered_o(digits_entered_o),
    .tries_left_o    (tries_left_o),
    .seconds_left_o  (seconds_left_o),
    .event_res_o     (event_res_o),
    .lamp_waiting_o  (lamp_waiting_o),
    .lamp_lockout_o  (lamp_lockout_o),
    .lamp_open_o     (lamp_open_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic reset_lock_model();
    cfg_attempts = MAX_ATT_RST;
    cfg_secs     = LOCK_SEC_RST;
    lk_phase     = PH_SET;
    lk_have_code = 1'b0;
    lk_digits    = '0;
    lk_tries     = MAX_ATT_RST;
    lk_secs      = '0;
  endtask

  // Apply one accepted beat to the lock model and queue the status it yields.
  task automatic advance_lock_model(input logic m, input logic [KEY_W-1:0] k);
    result_t st;
    event_e  ev;
    int      slot;
    bit      same;
    ev = EV_NONE;
    if (m == MODE_TICK) begin
      // ticks only count during lockout; the last one raises the prompt
      if (lk_phase == PH_LOCK) begin
        if (lk_secs <= 1) begin
          lk_secs  = '0;
          lk_phase = PH_PROMPT;
          ev       = EV_PROMPT;
        end else begin
          lk_secs = lk_secs - 1'b1;
        end
      end
    end else begin
      slot = (lk_digits >= CODE_LEN) ? 0 : lk_digits;
      case (lk_phase)
        PH_SET: begin
          lk_secret[slot] = k;
          lk_digits = DIGIT_W'(slot + 1);
          if (lk_digits < CODE_LEN) begin
            ev = EV_KEY;
          end else begin
            lk_digits    = '0;
            lk_have_code = 1'b1;
            lk_tries     = cfg_attempts;
            lk_phase     = PH_ENTRY;
            ev           = EV_STORED;
          end
        end
        PH_ENTRY: begin
          lk_typed[slot] = k;
          lk_digits = DIGIT_W'(slot + 1);
          if (lk_digits < CODE_LEN) begin
            ev = EV_KEY;
          end else begin
            lk_digits = '0;
            same = lk_have_code;
            for (int i = 0; i < CODE_LEN; i++) same &= (lk_typed[i] == lk_secret[i]);
            if (same) begin
              lk_phase = PH_OPEN;
              ev       = EV_OPENED;
            end else if (lk_tries <= 1) begin
              // out of tries: lockout instead of a plain wrong entry
              lk_tries = '0;
              lk_secs  = cfg_secs;
              lk_phase = PH_LOCK;
              ev       = EV_LOCKOUT;
            end else begin
              lk_tries = lk_tries - 1'b1;
              ev       = EV_WRONG;
            end
          end
        end
        PH_PROMPT: begin
          lk_digits = '0;
          if (k == KEY_YES) begin
            lk_have_code = 1'b0;
            lk_tries     = cfg_attempts;
            lk_phase     = PH_SET;
            ev           = EV_RESET_Y;
          end else begin
            // one more try; the next wrong entry locks out again
            lk_tries = TRIES_W'(1);
            lk_phase = PH_ENTRY;
            ev       = EV_RESET_N;
          end
        end
        default: ;  // keys in lockout and anything once open change nothing
      endcase
    end
    st.phase        = lk_phase;
    st.digits       = lk_digits;
    st.tries        = lk_tries;
    st.seconds      = lk_secs;
    st.ev           = ev;
    st.lamp_waiting = (lk_phase == PH_ENTRY);
    st.lamp_lockout = (lk_phase == PH_LOCK);
    st.lamp_open    = (lk_phase == PH_OPEN);
    pending_status.push_back(st);
  endtask

  // The lock opens for good, so random entries must never hit the code.
  function automatic logic [KEY_W-1:0] guard_key(input logic [KEY_W-1:0] k);
    bit same;
    same = (lk_phase == PH_ENTRY) && (lk_digits == CODE_LEN - 1) && lk_have_code &&
           (k == lk_secret[CODE_LEN-1]);
    for (int i = 0; i < CODE_LEN - 1; i++) same &= (lk_typed[i] == lk_secret[i]);
    return same ? ~k : k;
  endfunction

  // One beat on the input channel; gaps come in random bursts.
  task automatic send_beat(input logic m, input logic [KEY_W-1:0] k);
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    key      <= k;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    advance_lock_model(m, k);
  endtask

  // Drop valid and wait until every owed status beat has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [TRIES_W-1:0] attempts,
                             input logic [SEC_W-1:0] secs);
    logic [CFG_W-TRIES_W-1:0] upper;
    int raw;
    raw   = $urandom_range(0, 7);   // unused bits above max_attempts
    upper = raw[CFG_W-TRIES_W-1:0];
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MAX_ATTEMPTS;
    cfg_wdata <= {upper, attempts};
    @(negedge clk);
    cfg_idx   <= CFG_LOCKOUT_SEC;
    cfg_wdata <= secs;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_attempts = attempts;
    cfg_secs     = secs;
  endtask

  // Drive the lock to the start of a code in the goal phase, never opening it.
  task automatic steer_to(input phase_e goal);
    logic [KEY_W-1:0] k;
    while (!(lk_phase == goal && lk_digits == 0)) begin
      k = KEY_W'($urandom_range(0, 255));
      k = guard_key(k);
      case (lk_phase)
        PH_LOCK:   send_beat(MODE_TICK, k);
        PH_PROMPT: send_beat(MODE_KEY, (goal == PH_SET) ? KEY_YES : ~KEY_YES);
        default:   send_beat(MODE_KEY, k);
      endcase
    end
  endtask

  // Mostly well-formed traffic for the current phase, some ignored noise.
  task automatic pick_item(output logic m, output logic [KEY_W-1:0] k);
    int roll;
    int j;
    roll = $urandom_range(0, 99);
    m = MODE_KEY;
    k = KEY_W'($urandom_range(0, 255));
    case (lk_phase)
      PH_SET: if (roll < 8) m = MODE_TICK;
      PH_ENTRY: begin
        if (roll < 8) begin
          m = MODE_TICK;
        end else begin
          if (lk_digits == 0) begin
            // new entry: either all random or the code with one byte off
            for (int i = 0; i < CODE_LEN; i++)
              entry_plan[i] = (roll < 40) ? lk_secret[i] : KEY_W'($urandom_range(0, 255));
            if (roll < 40) begin
              j = $urandom_range(0, CODE_LEN - 1);
              entry_plan[j] = entry_plan[j] ^ KEY_W'($urandom_range(1, 255));
            end
          end
          k = guard_key(entry_plan[lk_digits[IDX_W-1:0]]);
        end
      end
      PH_LOCK: if (roll >= 6) m = MODE_TICK;
      PH_PROMPT: begin
        if (roll < 6) m = MODE_TICK;
        else if (roll < 45) k = KEY_YES;
      end
      default: m = roll[0];
    endcase
  endtask

  // Sends until n beats that the block acts on have gone; ignored ones are free.
  task automatic run_random(input int n_items);
    logic m;
    logic [KEY_W-1:0] k;
    int   done;
    bit   ignored;
    done = 0;
    while (done < n_items) begin
      pick_item(m, k);
      ignored = (lk_phase == PH_OPEN) ||
                ((m == MODE_TICK) ? (lk_phase != PH_LOCK) : (lk_phase == PH_LOCK));
      send_beat(m, k);
      if (!ignored) done++;
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Reset values of both registers: tries start at 5, lockouts last 20 ticks.
  task automatic test_reset_values();
    run_random(300);
  endtask

  // Lockout, prompt and both reset answers with one try and a two-tick lockout.
  task automatic test_directed_walk();
    reconfigure(1, 2);
    steer_to(PH_SET);
    send_beat(MODE_KEY, 8'h00);
    send_beat(MODE_KEY, 8'hFF);
    send_beat(MODE_KEY, KEY_YES);
    send_beat(MODE_KEY, 8'hA5);        // code stored
    send_beat(MODE_TICK, 8'hFF);       // tick outside lockout is ignored
    send_beat(MODE_KEY, 8'hFF);
    send_beat(MODE_KEY, 8'h00);
    send_beat(MODE_KEY, KEY_YES);
    send_beat(MODE_KEY, 8'hA5);        // last wrong entry: lockout
    send_beat(MODE_KEY, KEY_YES);      // key in lockout is ignored
    send_beat(MODE_TICK, 8'h00);       // countdown 2 -> 1
    send_beat(MODE_TICK, 8'h00);       // countdown end: prompt
    send_beat(MODE_KEY, 8'h41);        // reset no, one try left
    send_beat(MODE_KEY, 8'h00);
    send_beat(MODE_KEY, 8'hFF);
    send_beat(MODE_KEY, KEY_YES);
    send_beat(MODE_KEY, 8'h5A);        // wrong again: straight into lockout
    send_beat(MODE_TICK, 8'h00);
    send_beat(MODE_TICK, 8'hFF);
    send_beat(MODE_KEY, KEY_YES);      // reset yes: code erased
    send_beat(MODE_TICK, 8'h00);
  endtask

  task automatic test_long_lockout();
    reconfigure(7, 63);
    run_random(400);
  endtask

  task automatic test_short_lockout();
    reconfigure(1, 1);
    run_random(350);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      reconfigure(TRIES_W'($urandom_range(1, 7)), SEC_W'($urandom_range(1, 63)));
      run_random(120);
    end
  endtask

  // Receiver holds off while the sender keeps offering: buffer fills, input
  // stalls. Then the sender waits for every owed beat before going on.
  task automatic test_full_buffer();
    src_idle_en   = 1'b0;
    sink_hold_len = LONG_HOLD;
    run_random(60);
    drain_results();
    src_idle_en = 1'b1;
  endtask

  task automatic test_no_idling();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    reconfigure(TRIES_W'($urandom_range(1, 7)), SEC_W'($urandom_range(1, 63)));
    run_random(300);
  endtask

  // Opening is final, so it comes last, followed by beats it must ignore.
  task automatic test_open_for_good();
    steer_to(PH_ENTRY);
    for (int i = 0; i < CODE_LEN; i++) send_beat(MODE_KEY, lk_secret[i]);
    send_beat(MODE_TICK, 8'h00);
    send_beat(MODE_KEY, KEY_YES);
    send_beat(MODE_KEY, 8'hFF);
    send_beat(MODE_KEY, 8'h00);
  endtask

  // --------------------------------------------------------------- main

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_MAX_ATTEMPTS;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    mode         = MODE_KEY;
    key          = '0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    reset_lock_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_directed_walk();
    test_long_lockout();
    test_short_lockout();
    test_random_settings();
    test_full_buffer();
    test_no_idling();
    test_open_for_good();

    drain_results();
    if (pending_status.size() != 0)
      flag_mismatch($sformatf("%0d status beats never came", pending_status.size()));
    if (mismatches == 0) begin
      $display("** keypad_code_lock_unit: PASSED **");
    end else begin
      $display("** keypad_code_lock_unit: FAILED **");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus a long hold-off when a test asks.
  initial begin : receiver
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_len > 0) begin
        hold = sink_hold_len;
        sink_hold_len = 0;
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end else if (sink_idle_en && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted status beat is matched against the oldest one owed.
  initial begin : status_check
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid_o === 1'b1 && out_stall == 1'b0) begin
        if (pending_status.size() == 0) begin
          flag_mismatch("status beat with none owed");
        end else begin
          want = pending_status.pop_front();
          if (phase_o !== want.phase)
            flag_mismatch($sformatf("phase got %0d want %0d", phase_o, want.phase));
          if (digits_entered_o !== want.digits)
            flag_mismatch($sformatf("digits got %0d want %0d", digits_entered_o,
                                    want.digits));
          if (tries_left_o !== want.tries)
            flag_mismatch($sformatf("tries got %0d want %0d", tries_left_o, want.tries));
          if (seconds_left_o !== want.seconds)
            flag_mismatch($sformatf("seconds got %0d want %0d", seconds_left_o,
                                    want.seconds));
          if (event_res_o !== want.ev)
            flag_mismatch($sformatf("event got %0d want %0d", event_res_o, want.ev));
          if (lamp_waiting_o !== want.lamp_waiting)
            flag_mismatch($sformatf("waiting lamp got %b want %b", lamp_waiting_o,
                                    want.lamp_waiting));
          if (lamp_lockout_o !== want.lamp_lockout)
            flag_mismatch($sformatf("lockout lamp got %b want %b", lamp_lockout_o,
                                    want.lamp_lockout));
          if (lamp_open_o !== want.lamp_open)
            flag_mismatch($sformatf("open lamp got %b want %b", lamp_open_o,
                                    want.lamp_open));
        end
      end
    end
  end

  // Watchdog: too long without a beat on either side ends the run.
  initial begin : watchdog
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("[%0t] no beat moved for %0d cycles", $time, STALL_LIMIT);
    $display("** keypad_code_lock_unit: FAILED **");
    $finish;
  end

endmodule
